@@ rtl/avps_pkg.sv @@
// avps_pkg: shared widths, message codes, register indexes and the priority
// encoder for the alert voice priority sequencer.
// No dependencies.
package avps_pkg;

    localparam int TIME_W    = 32;
    localparam int ALARM_W   = 11;
    localparam int TRIG_W    = 5;
    localparam int ACTION_W  = 7;
    localparam int MSG_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 4;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [MSG_W-1:0]  msg_t;
    typedef logic [IDX_W-1:0]  bit_idx_t;

    localparam msg_t MSG_NONE       = 5'd0;
    localparam msg_t MSG_ALARM_BASE = 5'd1;
    localparam msg_t MSG_TRIG_BASE  = 5'd12;
    localparam msg_t MSG_ACT_BASE   = 5'd17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_HOLD = 2'd0,
        CFG_PLAY_ON      = 2'd1,
        CFG_PLAY_OFF     = 2'd2
    } cfg_idx_t;

    localparam time_t TRIGGER_HOLD_RST = 32'd3000;
    localparam time_t PLAY_ON_RST      = 32'd2000;
    localparam time_t PLAY_OFF_RST     = 32'd1000;

    // index of lowest set bit, 0 when no bit is set
    function automatic bit_idx_t lowest_bit(input logic [ALARM_W-1:0] v);
        bit_idx_t idx;
        idx = '0;
        for (int i = ALARM_W - 1; i >= 0; i--) begin
            if (v[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/avps_item_if.sv @@
// avps_item_if: input tick channel (valid/ready plus one tick's fields).
// Depends on avps_pkg.
interface avps_item_if;
    logic                           valid;
    logic                           ready;
    logic [avps_pkg::TIME_W-1:0]    time_ms;
    logic [avps_pkg::ALARM_W-1:0]   alarm_levels;
    logic [avps_pkg::TRIG_W-1:0]    trigger_pulses;
    logic [avps_pkg::ACTION_W-1:0]  action_levels;

    modport source (output valid, time_ms, alarm_levels, trigger_pulses, action_levels,
                    input ready);
    modport sink   (input valid, time_ms, alarm_levels, trigger_pulses, action_levels,
                    output ready);
endinterface

@@ rtl/avps_result_if.sv @@
// avps_result_if: result channel (valid/ready plus command, message, flags).
// Depends on avps_pkg.
interface avps_result_if;
    logic                         valid;
    logic                         ready;
    logic [avps_pkg::MSG_W-1:0]   play_command;
    logic [avps_pkg::MSG_W-1:0]   current_message;
    logic [avps_pkg::TRIG_W-1:0]  sticky_flags;

    modport source (output valid, play_command, current_message, sticky_flags,
                    input ready);
    modport sink   (input valid, play_command, current_message, sticky_flags,
                    output ready);
endinterface

@@ rtl/avps_cfg_if.sv @@
// avps_cfg_if: configuration write channel (valid/ready, register index, data).
// Depends on avps_pkg.
interface avps_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [avps_pkg::CFG_IDX_W-1:0]  index;
    logic [avps_pkg::TIME_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/alert_voice_priority_sequencer.sv @@
// alert_voice_priority_sequencer: picks one voice message per tick and drives
// the on/off play command. Depends on avps_pkg and the avps_*_if interfaces.
//
// One result per input tick. A tick is captured in an input register, then
// evaluated combinationally against the held state into the result register,
// so a new tick is taken every cycle while the result side accepts results.
// Backpressure on the result side stalls the input register.
// Configuration writes are always taken (ready tied high); unknown indexes are
// ignored. Registers reset to hold 3000, on 2000, off 1000.
module alert_voice_priority_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    avps_item_if.sink     item,
    avps_result_if.source result,
    avps_cfg_if.sink      cfg
);
    import avps_pkg::*;

    // configuration
    time_t trigger_hold_reg;
    time_t play_on_reg;
    time_t play_off_reg;

    // input stage
    logic                  in_valid_reg;
    time_t                 in_time_reg;
    logic [ALARM_W-1:0]    in_alarm_reg;
    logic [TRIG_W-1:0]     in_pulse_reg;
    logic [ACTION_W-1:0]   in_action_reg;

    // sequencer state
    msg_t                  last_message_reg, last_message_next;
    time_t                 change_time_reg, change_time_next;
    time_t                 toggle_time_reg, toggle_time_next;
    msg_t                  command_reg, command_next;
    logic [TRIG_W-1:0]     pending_reg, pending_next;

    // result stage
    logic                  out_valid_reg;
    msg_t                  out_command_reg;
    msg_t                  out_message_reg;
    logic [TRIG_W-1:0]     out_flags_reg;

    logic                  advance;
    logic                  fire;
    logic [TRIG_W-1:0]     pend_merged;
    msg_t                  msg;
    bit_idx_t              trig_bit;
    logic                  is_trigger;
    time_t                 elapsed;

    assign advance    = !out_valid_reg || result.ready;
    assign fire       = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        pend_merged       = pending_reg | in_pulse_reg;
        trig_bit          = lowest_bit({{(ALARM_W-TRIG_W){1'b0}}, pend_merged});
        is_trigger        = 1'b0;
        msg               = MSG_NONE;
        last_message_next = last_message_reg;
        change_time_next  = change_time_reg;
        toggle_time_next  = toggle_time_reg;
        command_next      = command_reg;
        pending_next      = pend_merged;
        elapsed           = '0;

        if (in_alarm_reg != '0)
        begin
            msg = MSG_ALARM_BASE + MSG_W'(lowest_bit(in_alarm_reg));
        end
        else if (pend_merged != '0)
        begin
            msg        = MSG_TRIG_BASE + MSG_W'(trig_bit);
            is_trigger = 1'b1;
        end
        else if (in_action_reg != '0)
        begin
            msg = MSG_ACT_BASE +
                  MSG_W'(lowest_bit({{(ALARM_W-ACTION_W){1'b0}}, in_action_reg}));
        end

        if (msg != last_message_reg)
        begin
            last_message_next = msg;
            change_time_next  = in_time_reg;
            command_next      = msg;
        end

        if (is_trigger && ((in_time_reg - change_time_next) > trigger_hold_reg))
        begin
            pending_next[trig_bit[$clog2(TRIG_W)-1:0]] = 1'b0;
        end

        if (msg != MSG_NONE)
        begin
            elapsed = in_time_reg - toggle_time_reg;
            if (elapsed >= play_on_reg && command_next != MSG_NONE)
            begin
                command_next     = MSG_NONE;
                toggle_time_next = in_time_reg;
            end
            else if (elapsed >= play_off_reg && command_next == MSG_NONE)
            begin
                command_next     = msg;
                toggle_time_next = in_time_reg;
            end
        end
        else
        begin
            command_next = MSG_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_hold_reg <= TRIGGER_HOLD_RST;
            play_on_reg      <= PLAY_ON_RST;
            play_off_reg     <= PLAY_OFF_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TRIGGER_HOLD: trigger_hold_reg <= cfg.data;
                CFG_PLAY_ON:      play_on_reg      <= cfg.data;
                CFG_PLAY_OFF:     play_off_reg     <= cfg.data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            last_message_reg <= MSG_NONE;
            change_time_reg  <= '0;
            toggle_time_reg  <= '0;
            command_reg      <= MSG_NONE;
            pending_reg      <= '0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                last_message_reg <= last_message_next;
                change_time_reg  <= change_time_next;
                toggle_time_reg  <= toggle_time_next;
                command_reg      <= command_next;
                pending_reg      <= pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_time_reg   <= item.time_ms;
            in_alarm_reg  <= item.alarm_levels;
            in_pulse_reg  <= item.trigger_pulses;
            in_action_reg <= item.action_levels;
        end
        if (fire)
        begin
            out_command_reg <= command_next;
            out_message_reg <= msg;
            out_flags_reg   <= pending_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.play_command    = out_command_reg;
    assign result.current_message = out_message_reg;
    assign result.sticky_flags    = out_flags_reg;

endmodule
